// File: hw/rtl/pihdc_pkg.sv
package pihdc_pkg;

  // Register map, in word order on the configuration port.
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_TARGET     = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_DUTY_LIMIT = 3'd4
  } reg_idx_t;

  localparam int TEMP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 17;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int INTEG_W = 32;
  // Signed product of a gain and an error, and of a gain and the integral.
  localparam int PE_W    = 34;
  localparam int PI_W    = 48;
  localparam int SUM_W   = PI_W + 1;
  localparam int ADDR_W  = 5;

  localparam logic signed [TEMP_W-1:0] TARGET_RESET     = 16'sd12800;
  localparam logic        [DUTY_W-1:0] DUTY_LIMIT_RESET = 17'd125000;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

endpackage

// File: hw/rtl/pi_heater_duty_controller.sv
// PI heater duty controller with conditional-integration anti-windup.
//
// Input channel: one signed Q8.8 temperature sample per item on in_temperature,
// taken when in_valid and in_ready are both high. Result channel: one item per
// input item, out_duty (ns, 0..duty_limit) and out_driven, under out_valid and
// out_ready. Registers are written through the APB port (psel, penable, ...).
//
// The datapath is a four-register pipeline: error, gain products, integral
// update, and clamped duty. One item can be taken every cycle unless the
// receiver stalls or gain_i is reloaded. The loop that carries state from
// item to item is the integral update stage; it keeps the integral and its
// product with gain_i, so no multiplier sits inside that loop.
//
// Writing gain_i reloads that product in the following cycle, and in_ready is
// low for that one cycle. Reset clears the integral and all valid flags and
// loads the register defaults (disabled, 50.0 C target, 125000 ns limit).
// When the receiver stalls, items collect in the empty pipeline registers and
// in_ready drops, outside a gain_i reload, only once all four are full.
module pi_heater_duty_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pihdc_pkg::TEMP_W-1:0]  in_temperature,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [pihdc_pkg::DUTY_W-1:0]  out_duty,
  output logic                                 out_driven,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [pihdc_pkg::ADDR_W-1:0]  paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready
);

  // Configuration registers.
  logic                                 enable_r;
  logic signed [pihdc_pkg::TEMP_W-1:0]  target_r;
  logic        [pihdc_pkg::GAIN_W-1:0]  gain_p_r;
  logic        [pihdc_pkg::GAIN_W-1:0]  gain_i_r;
  logic        [pihdc_pkg::DUTY_W-1:0]  duty_limit_r;
  logic                                 recalc_r;

  // Loop state: the integral and gain_i times the integral.
  logic signed [pihdc_pkg::INTEG_W-1:0] integ_r;
  logic signed [pihdc_pkg::PI_W-1:0]    prod_r;

  // Pipeline registers.
  logic                                 va_r, vb_r, vc_r, out_valid_r;
  logic signed [pihdc_pkg::ERR_W-1:0]   err_a_r, err_b_r;
  logic signed [pihdc_pkg::PE_W-1:0]    gpe_b_r, gie_b_r, gpe_c_r;
  logic signed [pihdc_pkg::PI_W-1:0]    prod_c_r;
  logic        [pihdc_pkg::DUTY_W-1:0]  out_duty_r;
  logic                                 out_driven_r;

  logic                                 cfg_wr;
  logic                                 rdy_a, rdy_b, rdy_c, rdy_d;
  logic                                 mv_a, mv_b, mv_c, mv_d;

  logic signed [pihdc_pkg::ERR_W-1:0]   err_nxt;
  logic signed [pihdc_pkg::PE_W-1:0]    gpe_nxt, gie_nxt;
  logic signed [pihdc_pkg::PI_W-1:0]    recalc_nxt;
  logic signed [pihdc_pkg::PI_W-1:0]    thr, prod_hi, prod_lo, prod_add;
  logic signed [pihdc_pkg::INTEG_W:0]   isum;
  logic                                 ovf_hi, ovf_lo, integ_go;
  logic signed [pihdc_pkg::INTEG_W-1:0] integ_nxt;
  logic signed [pihdc_pkg::PI_W-1:0]    prod_nxt;
  logic signed [pihdc_pkg::SUM_W-1:0]   sum;
  logic        [pihdc_pkg::SUM_W-10:0]  sum_sh;
  logic        [pihdc_pkg::DUTY_W-1:0]  duty_nxt;

  // ---------------- Configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (pihdc_pkg::reg_idx_t'(paddr[4:2]))
      pihdc_pkg::REG_ENABLE:     prdata = {31'b0, enable_r};
      pihdc_pkg::REG_TARGET:     prdata = 32'(target_r);
      pihdc_pkg::REG_GAIN_P:     prdata = {16'b0, gain_p_r};
      pihdc_pkg::REG_GAIN_I:     prdata = {16'b0, gain_i_r};
      pihdc_pkg::REG_DUTY_LIMIT: prdata = {15'b0, duty_limit_r};
      default:                   prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      target_r     <= pihdc_pkg::TARGET_RESET;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      duty_limit_r <= pihdc_pkg::DUTY_LIMIT_RESET;
      recalc_r     <= 1'b0;
    end else begin
      recalc_r <= 1'b0;
      if (cfg_wr) begin
        case (pihdc_pkg::reg_idx_t'(paddr[4:2]))
          pihdc_pkg::REG_ENABLE:     enable_r     <= pwdata[0];
          pihdc_pkg::REG_TARGET:     target_r     <= pwdata[15:0];
          pihdc_pkg::REG_GAIN_P:     gain_p_r     <= pwdata[15:0];
          pihdc_pkg::REG_GAIN_I: begin
            gain_i_r <= pwdata[15:0];
            recalc_r <= 1'b1;
          end
          pihdc_pkg::REG_DUTY_LIMIT: duty_limit_r <= pwdata[16:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- Handshake chain ----------------
  assign rdy_d    = !out_valid_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a && !recalc_r;

  assign mv_a = in_valid && in_ready;
  assign mv_b = va_r && rdy_b;
  assign mv_c = vb_r && rdy_c;
  assign mv_d = vc_r && rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= mv_a;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) out_valid_r <= vc_r;
    end
  end

  // ---------------- Stage A: error ----------------
  assign err_nxt = {target_r[15], target_r} - {in_temperature[15], in_temperature};

  // ---------------- Stage B: gain products ----------------
  assign gpe_nxt = $signed({1'b0, gain_p_r}) * err_a_r;
  assign gie_nxt = $signed({1'b0, gain_i_r}) * err_a_r;

  // ---------------- Stage C: integral update ----------------
  // |integral| * gain_i >> 8 < limit is the same as the stored product lying
  // strictly between -(limit << 8) and (limit << 8).
  assign thr      = $signed({23'b0, duty_limit_r, 8'b0});
  assign integ_go = enable_r && (prod_r < thr) && (prod_r > -thr);

  assign isum   = {integ_r[31], integ_r} + {{16{err_b_r[16]}}, err_b_r};
  assign ovf_hi = !isum[32] && isum[31];
  assign ovf_lo = isum[32] && !isum[31];

  // gain_i times the saturated integral values, built from shifts.
  assign prod_hi  = $signed({1'b0, gain_i_r, 31'b0}) - $signed({32'b0, gain_i_r});
  assign prod_lo  = -$signed({1'b0, gain_i_r, 31'b0});
  assign prod_add = prod_r + {{14{gie_b_r[33]}}, gie_b_r};

  always_comb begin
    integ_nxt = integ_r;
    prod_nxt  = prod_r;
    if (integ_go) begin
      if (ovf_hi) begin
        integ_nxt = pihdc_pkg::INTEG_MAX;
        prod_nxt  = prod_hi;
      end else if (ovf_lo) begin
        integ_nxt = pihdc_pkg::INTEG_MIN;
        prod_nxt  = prod_lo;
      end else begin
        integ_nxt = isum[31:0];
        prod_nxt  = prod_add;
      end
    end
  end

  assign recalc_nxt = $signed({1'b0, gain_i_r}) * integ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prod_r  <= '0;
    end else if (recalc_r) begin
      prod_r <= recalc_nxt;
    end else if (mv_c) begin
      integ_r <= integ_nxt;
      prod_r  <= prod_nxt;
    end
  end

  // ---------------- Stage D: command and clamp ----------------
  assign sum    = {{15{gpe_c_r[33]}}, gpe_c_r} + {prod_c_r[47], prod_c_r};
  assign sum_sh = sum[47:8];

  always_comb begin
    if (!enable_r || sum[48] || (sum == '0)) begin
      duty_nxt = '0;
    end else if (sum_sh > {23'b0, duty_limit_r}) begin
      duty_nxt = duty_limit_r;
    end else begin
      duty_nxt = sum_sh[16:0];
    end
  end

  // ---------------- Payload registers ----------------
  always_ff @(posedge clk) begin
    if (mv_a) err_a_r <= err_nxt;
    if (mv_b) begin
      err_b_r <= err_a_r;
      gpe_b_r <= gpe_nxt;
      gie_b_r <= gie_nxt;
    end
    if (mv_c) begin
      gpe_c_r  <= gpe_b_r;
      prod_c_r <= prod_nxt;
    end
    if (mv_d) begin
      out_duty_r   <= duty_nxt;
      out_driven_r <= enable_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_duty   = out_duty_r;
  assign out_driven = out_driven_r;

  // ---------------- Assertions ----------------
  // No sample may enter while the integral product is being reloaded.
  a_no_accept_in_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    recalc_r |-> !in_ready)
    else $error("item accepted during product reload");

  // A result that is not driven carries zero duty.
  a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_driven_r) |-> (out_duty_r == '0))
    else $error("undriven result with nonzero duty");

  // The integral only moves when an item passes the update stage.
  a_integ_moves_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    !mv_c |=> $stable(integ_r))
    else $error("integral changed without an item");

  // A full pipeline with a stalled result blocks new items.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && vb_r && vc_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("item accepted into a full pipeline");

endmodule
